@@ design/url_ft_pkg.sv @@
// Shared types and constants for the URL field tokenizer.
package url_ft_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [3:0] {
        TAG_IGNORED = 4'd0,
        TAG_LEAD    = 4'd1,
        TAG_DELIM   = 4'd2,
        TAG_SCHEME  = 4'd3,
        TAG_HOST    = 4'd4,
        TAG_PORT    = 4'd5,
        TAG_PATH    = 4'd6,
        TAG_QUERY   = 4'd7,
        TAG_FRAG    = 4'd8
    } field_tag_t;

    typedef enum logic [10:0] {
        PH_LEAD   = 11'b000_0000_0001,
        PH_SCHEME = 11'b000_0000_0010,
        PH_COLON  = 11'b000_0000_0100,
        PH_SLASH1 = 11'b000_0000_1000,
        PH_HOST   = 11'b000_0001_0000,
        PH_PORT   = 11'b000_0010_0000,
        PH_PATH   = 11'b000_0100_0000,
        PH_QUERY  = 11'b000_1000_0000,
        PH_FRAG   = 11'b001_0000_0000,
        PH_FRAGND = 11'b010_0000_0000,
        PH_FAILED = 11'b100_0000_0000
    } phase_t;

    // Classifier verdict for one byte.
    typedef struct packed {
        field_tag_t tag;
        logic       fail;
        phase_t     phase_next;
    } class_res_t;

endpackage

@@ design/url_ft_classify.sv @@
// Per-byte field classifier: tag, failure flag and next parse phase.
module url_ft_classify (
    input  url_ft_pkg::phase_t     phase,
    input  logic [7:0]             char_in,
    input  logic                   last,
    output url_ft_pkg::class_res_t res
);
    import url_ft_pkg::*;

    field_tag_t tag;
    phase_t     ph;

    always_comb begin
        tag = TAG_IGNORED;
        ph  = phase;
        case (phase)
            PH_LEAD: begin
                if (char_in == CH_SPACE) begin
                    tag = TAG_LEAD;
                end else if (char_in == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_PATH;
                end else if (char_in == CH_COLON) begin
                    tag = TAG_DELIM;
                    ph  = PH_COLON;
                end else begin
                    tag = TAG_SCHEME;
                    ph  = PH_SCHEME;
                end
            end
            PH_SCHEME: begin
                if (char_in == CH_COLON) begin
                    tag = TAG_DELIM;
                    ph  = PH_COLON;
                end else begin
                    tag = TAG_SCHEME;
                end
            end
            PH_COLON: begin
                if (char_in == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_SLASH1;
                end else begin
                    ph  = PH_FAILED;
                end
            end
            PH_SLASH1: begin
                if (char_in == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_HOST;
                end else begin
                    ph  = PH_FAILED;
                end
            end
            PH_HOST: begin
                if (char_in == CH_COLON) begin
                    tag = TAG_DELIM;
                    ph  = PH_PORT;
                end else if (char_in == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_PATH;
                end else if (char_in == CH_QMARK) begin
                    tag = TAG_DELIM;
                    ph  = PH_QUERY;
                end else begin
                    tag = TAG_HOST;
                end
            end
            PH_PORT: begin
                if (char_in == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_PATH;
                end else if (char_in == CH_QMARK) begin
                    tag = TAG_DELIM;
                    ph  = PH_QUERY;
                end else begin
                    tag = TAG_PORT;
                end
            end
            PH_PATH: begin
                if (char_in == CH_QMARK) begin
                    tag = TAG_DELIM;
                    ph  = PH_QUERY;
                end else if (char_in == CH_HASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_FRAG;
                end else begin
                    tag = TAG_PATH;
                end
            end
            PH_QUERY: begin
                if (char_in == CH_HASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_FRAG;
                end else begin
                    tag = TAG_QUERY;
                end
            end
            PH_FRAG: begin
                if (char_in == CH_NUL) begin
                    ph  = PH_FRAGND;
                end else begin
                    tag = TAG_FRAG;
                end
            end
            default: begin
                // fragment closed, failed, or illegal code: byte ignored
                tag = TAG_IGNORED;
            end
        endcase

        res.tag        = tag;
        // scheme never closed by "://" when the text ends here
        res.fail       = last && (ph == PH_LEAD || ph == PH_SCHEME || ph == PH_COLON ||
                                  ph == PH_SLASH1 || ph == PH_FAILED);
        res.phase_next = last ? PH_LEAD : ph;
    end

endmodule

@@ design/url_ft_outreg.sv @@
// Output pipeline register: holds one classified beat, refills every cycle in which it is empty or its beat is taken.
module url_ft_outreg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic [7:0]              char_in,
    input  url_ft_pkg::field_tag_t  tag_in,
    input  logic                    fail_in,
    input  logic                    last_in,
    output logic                    free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic [4:0]              m_tuser,
    output logic                    m_tlast
);
    import url_ft_pkg::*;

    logic       valid_reg;
    logic [7:0] char_reg;
    field_tag_t tag_reg;
    logic       fail_reg;
    logic       last_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= char_in;
            tag_reg  <= tag_in;
            fail_reg <= fail_in;
            last_reg <= last_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tuser  = {fail_reg, tag_reg};
    assign m_tlast  = last_reg;

endmodule

@@ design/url_field_tokenizer.sv @@
// Top level of the URL field tokenizer: phase register, classifier, output stage.
//
//  Channel | Ports                              | Contents
//  --------+------------------------------------+-----------------------------------
//  input   | s_tvalid s_tready s_tdata s_tlast  | tdata[7:0] char_in, tlast end_of_text
//  result  | m_tvalid m_tready m_tdata m_tuser  | tdata[7:0] char_out,
//          | m_tlast                            | tuser[3:0] field_tag,
//          |                                    | tuser[4] scheme_failed, tlast final
//
// One byte per cycle: each accepted beat is classified against the phase
// register in the same cycle and shows up on the result side in the next cycle.
// Throughput is set by the single output register; it refills while its
// current beat is taken, so the input stalls only while a result waits.
// Synchronous active-low reset returns the parser to the leading-space phase
// and empties the output register; s_tready is low during reset.
// The phase register also returns to the leading-space phase after each
// beat with tlast set, so URLs follow each other without a gap.
module url_field_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [4:0] m_tuser,   // [3:0] field_tag, [4] scheme_failed
    output logic       m_tlast
);
    import url_ft_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    class_res_t cls;
    logic       out_free;
    logic       accept;

    assign s_tready = aresetn && out_free;
    assign accept   = s_tvalid && s_tready;

    url_ft_classify u_classify (
        .phase   (phase_reg),
        .char_in (s_tdata),
        .last    (s_tlast),
        .res     (cls)
    );

    // parse phase advances only on an accepted beat
    assign phase_next = accept ? cls.phase_next : phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
        end else begin
            phase_reg <= phase_next;
        end
    end

    url_ft_outreg u_outreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .char_in  (s_tdata),
        .tag_in   (cls.tag),
        .fail_in  (cls.fail),
        .last_in  (s_tlast),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ design/url_ft_checker.sv @@
// Port-level checker for the URL field tokenizer and its bind.
module url_ft_assert (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [4:0] m_tuser,
    input logic       m_tlast
);

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !s_tready) |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

    // accepted beat shows up in the next cycle with its byte and last mark
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=>
            (m_tvalid && m_tdata == $past(s_tdata) && m_tlast == $past(s_tlast)))
        else $error("accepted beat not presented next cycle");

    // failure flag only on the final beat of a URL
    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4]) |-> m_tlast)
        else $error("scheme_failed on a non-final beat");

    // field tag stays within its code range
    a_tag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[3:0] <= 4'd8))
        else $error("field tag out of range");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind url_field_tokenizer url_ft_assert u_url_ft_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ sim/url_ft_checker.sv @@
`timescale 1ns / 1ps
// Checker for the URL field tokenizer: watches both channels, predicts each result and compares.
module url_ft_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] char_out
    input  logic [4:0] m_tuser,   // [3:0] field_tag, [4] scheme_failed
    input  logic       m_tlast,
    output int         mismatch_count,
    output int         tokens_pending
);
    import url_ft_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] data;
        field_tag_t tag;
        logic       last;
        logic       failed;
    } url_token_t;

    url_token_t expected_tokens[$];
    phase_t     parse_phase;

    // One byte against the current phase; returns the tagged byte and the next phase.
    function automatic url_token_t classify_byte(input logic [7:0] ch, input logic last_b,
                                                 input phase_t phase_now,
                                                 output phase_t phase_after);
        url_token_t tok;
        phase_t     ph;
        field_tag_t tag;
        ph  = phase_now;
        tag = TAG_IGNORED;
        case (phase_now)
            PH_LEAD: begin
                if (ch == CH_SPACE) begin
                    tag = TAG_LEAD;
                end else if (ch == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_PATH;
                end else if (ch == CH_COLON) begin
                    tag = TAG_DELIM;
                    ph  = PH_COLON;
                end else begin
                    tag = TAG_SCHEME;
                    ph  = PH_SCHEME;
                end
            end
            PH_SCHEME: begin
                if (ch == CH_COLON) begin
                    tag = TAG_DELIM;
                    ph  = PH_COLON;
                end else begin
                    tag = TAG_SCHEME;
                end
            end
            PH_COLON: begin
                if (ch == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_SLASH1;
                end else begin
                    ph = PH_FAILED;
                end
            end
            PH_SLASH1: begin
                if (ch == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_HOST;
                end else begin
                    ph = PH_FAILED;
                end
            end
            PH_HOST: begin
                if (ch == CH_COLON) begin
                    tag = TAG_DELIM;
                    ph  = PH_PORT;
                end else if (ch == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_PATH;
                end else if (ch == CH_QMARK) begin
                    tag = TAG_DELIM;
                    ph  = PH_QUERY;
                end else begin
                    tag = TAG_HOST;
                end
            end
            PH_PORT: begin
                if (ch == CH_SLASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_PATH;
                end else if (ch == CH_QMARK) begin
                    tag = TAG_DELIM;
                    ph  = PH_QUERY;
                end else begin
                    tag = TAG_PORT;
                end
            end
            PH_PATH: begin
                if (ch == CH_QMARK) begin
                    tag = TAG_DELIM;
                    ph  = PH_QUERY;
                end else if (ch == CH_HASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_FRAG;
                end else begin
                    tag = TAG_PATH;
                end
            end
            PH_QUERY: begin
                if (ch == CH_HASH) begin
                    tag = TAG_DELIM;
                    ph  = PH_FRAG;
                end else begin
                    tag = TAG_QUERY;
                end
            end
            PH_FRAG: begin
                if (ch == CH_NUL) begin
                    ph = PH_FRAGND;
                end else begin
                    tag = TAG_FRAG;
                end
            end
            default: begin
                // after a NUL in the fragment or a broken separator: ignore
            end
        endcase
        tok.data   = ch;
        tok.tag    = tag;
        tok.last   = last_b;
        tok.failed = last_b && (ph inside {PH_LEAD, PH_SCHEME, PH_COLON, PH_SLASH1, PH_FAILED});
        phase_after = last_b ? PH_LEAD : ph;
        return tok;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] url_ft_checker: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge aclk) begin : watch
        url_token_t predicted;
        url_token_t oldest;
        phase_t     next_phase;
        if (!aresetn) begin
            parse_phase = PH_LEAD;
            expected_tokens.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predicted = classify_byte(s_tdata, s_tlast, parse_phase, next_phase);
                parse_phase = next_phase;
                expected_tokens.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected beat, char_out", m_tdata, 0);
                end else begin
                    oldest = expected_tokens.pop_front();
                    if (m_tdata !== oldest.data)
                        report_mismatch("char_out", m_tdata, oldest.data);
                    if (m_tuser[3:0] !== oldest.tag)
                        report_mismatch("field_tag", m_tuser[3:0], oldest.tag);
                    if (m_tuser[4] !== oldest.failed)
                        report_mismatch("scheme_failed", m_tuser[4], oldest.failed);
                    if (m_tlast !== oldest.last)
                        report_mismatch("final_flag", m_tlast, oldest.last);
                end
            end
        end
        tokens_pending <= expected_tokens.size();
    end

endmodule

@@ sim/tb_url_field_tokenizer.sv @@
`timescale 1ns / 1ps
// Testbench top for the URL field tokenizer: clock, reset, URL stimulus, stalls and verdict.
module tb_url_field_tokenizer;
    import url_ft_pkg::*;

    localparam int RANDOM_BEATS   = 850;
    // Longest legal quiet stretch is a send gap plus a chain of receiver stalls;
    // the limit allows for it many times over.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_in
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] char_out
    logic [4:0] m_tuser;   // [3:0] field_tag, [4] scheme_failed
    logic       m_tlast;

    int mismatch_count;
    int tokens_pending;

    logic [7:0] url_text[$];   // bytes of the URL being sent
    int         beats_sent;
    int         idle_cycles;
    int         ready_hold;
    bit         gaps_on;

    url_field_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    url_ft_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .tokens_pending (tokens_pending)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Receiver back-pressure: short ready/stall bursts, some long free-running
    // stretches and a few long stalls. One assignment per edge.
    always @(posedge aclk) begin : ready_gen
        int r;
        if (ready_hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 7);
            end else if (r < 62) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(20, 60);
            end else if (r < 92) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 30);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Gap after a beat: mostly none, some short, a few long.
    function automatic int beat_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly URL-ish text, sometimes any byte at all (delimiters included).
    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 80)
            return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            url_text.push_back(s[i]);
    endtask

    task automatic push_text(input int n);
        repeat (n) url_text.push_back(text_byte());
    endtask

    // Valid stays high across back-to-back beats; it only drops for a gap.
    task automatic send_beat(input logic [7:0] data, input logic last_b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last_b;
        do @(posedge aclk); while (!s_tready);
        beats_sent = beats_sent + 1;
        gap = beat_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_url();
        for (int i = 0; i < url_text.size(); i++)
            send_beat(url_text[i], i == url_text.size() - 1);
        url_text.delete();
    endtask

    // Path, query and fragment in random combination, with an optional NUL
    // that closes the fragment followed by trailing junk.
    task automatic push_tail();
        if ($urandom_range(0, 2) != 0)
            push_text($urandom_range(0, 6));
        if ($urandom_range(0, 1) == 1) begin
            url_text.push_back(CH_QMARK);
            push_text($urandom_range(0, 6));
        end
        if ($urandom_range(0, 1) == 1) begin
            url_text.push_back(CH_HASH);
            push_text($urandom_range(0, 5));
            if ($urandom_range(0, 2) == 0) begin
                url_text.push_back(CH_NUL);
                push_text($urandom_range(0, 3));
            end
        end
    endtask

    task automatic build_well_formed();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) url_text.push_back(CH_SPACE);
        if ($urandom_range(0, 5) == 0) begin
            // path-only URL
            url_text.push_back(CH_SLASH);
            push_tail();
        end else begin
            push_text($urandom_range(1, 5));
            push_str("://");
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    url_text.push_back(CH_HASH);
                else
                    url_text.push_back(text_byte());
            end
            if ($urandom_range(0, 2) == 0) begin
                url_text.push_back(CH_COLON);
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(0, 9) == 0)
                        url_text.push_back(CH_HASH);
                    else
                        url_text.push_back(text_byte());
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                url_text.push_back(CH_SLASH);
                push_tail();
            end else if ($urandom_range(0, 1) == 1) begin
                // query or fragment straight after the host
                push_tail();
            end
        end
    endtask

    task automatic build_random_url();
        int         r;
        int         keep;
        logic [7:0] bad;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            build_well_formed();
        end else if (r < 80) begin
            // early end somewhere inside an otherwise good URL
            build_well_formed();
            keep = $urandom_range(1, url_text.size());
            while (url_text.size() > keep)
                void'(url_text.pop_back());
        end else if (r < 90) begin
            // broken separator after ':' or ":/"
            push_text($urandom_range(1, 4));
            url_text.push_back(CH_COLON);
            if ($urandom_range(0, 1) == 1)
                url_text.push_back(CH_SLASH);
            do bad = 8'($urandom_range(0, 255)); while (bad == CH_SLASH);
            url_text.push_back(bad);
            push_text($urandom_range(0, 5));
        end else begin
            // raw noise
            repeat ($urandom_range(1, 10)) url_text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tlast    <= 1'b0;
        aresetn    <= 1'b0;
        beats_sent  = 0;
        gaps_on     = 1'b1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed URLs.
        // Leading space then '/', path, '#' from path, NUL ends fragment, junk after.
        push_str(" /p#");
        url_text.push_back(CH_NUL);
        push_str("x");
        send_url();
        // Leading space then a top-bit byte as scheme; '#' in host and port,
        // NUL as an ordinary port byte, query and fragment.
        url_text.push_back(CH_SPACE);
        url_text.push_back(8'hFF);
        push_str("://h#:#");
        url_text.push_back(CH_NUL);
        push_str("?q#f");
        send_url();
        // ':' right away, broken after ":/".
        push_str(":/x");
        send_url();
        // Broken right after ':'.
        push_str("a:x");
        send_url();
        // Text ends in the leading spaces, then right after ':'.
        push_str(" ");
        send_url();
        push_str("a:");
        send_url();

        // Random URLs.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            build_random_url();
            send_url();
        end
        s_tvalid <= 1'b0;

        // pending count is registered, so it lags behind the last accepted beat
        @(posedge aclk);
        while (tokens_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/url_ft_pkg.sv
design/url_ft_classify.sv
design/url_ft_outreg.sv
design/url_field_tokenizer.sv
design/url_ft_checker.sv
sim/url_ft_checker.sv
sim/tb_url_field_tokenizer.sv
